// ===== hw/rtl/rbls_pkg.sv =====
// Shared constants, request codes and types for the rotated bitboard line store.
// No dependencies; every other file in hw/rtl imports this package.
`timescale 1ns / 1ps

package rbls_pkg;

  // Board edge length. Cell coordinates arrive as 3-bit fields.
  localparam int BOARD_SIZE = 8;
  localparam int IDX_W      = (BOARD_SIZE > 8) ? $clog2(BOARD_SIZE) : 3;
  localparam int OUT_W      = 8;

  localparam logic [1:0] REQ_PLACE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [1:0] AXIS_HORIZ = 2'd0;
  localparam logic [1:0] AXIS_VERT  = 2'd1;
  localparam logic [1:0] AXIS_DIAG  = 2'd2;
  localparam logic [1:0] AXIS_ANTI  = 2'd3;

  typedef logic [BOARD_SIZE-1:0] row_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [BOARD_SIZE-1:0][BOARD_SIZE-1:0] board_t;

  // Where one cell lands in the four views, and which part of its wrapped
  // diagonal rows belongs to the cell's own line.
  typedef struct packed {
    logic on_board;
    idx_t x_idx;
    idx_t y_idx;
    idx_t diag_idx;
    idx_t anti_idx;
    row_t diag_keep;
    row_t anti_keep;
  } cell_geom_t;

endpackage

// ===== hw/rtl/rotated_bitboard_line_store_core.sv =====
// Top level of the rotated bitboard line store: input register, board views,
// update and line read logic, result register. Depends on rbls_pkg, rbls_cell_map.
`timescale 1ns / 1ps

// The block takes one request per clock cycle when the result side keeps up.
// Each item is captured in an input register and then resolved by a single
// pass of logic that updates the four board views and, for a read, loads the
// result register, so a line mask reaches the result port through the input
// register and then the result register. Place and clear items produce no result and never
// wait on the result side; a read waits only while the result register still
// holds an untaken mask. The board is all empty after reset and after a
// clear item, with no clearing pass, and an update is seen by the very next item.
module rotated_bitboard_line_store_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_req_type,
  input  logic [2:0] in_col,
  input  logic [2:0] in_row,
  input  logic       in_stone,
  input  logic [1:0] in_axis,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_line_mask
);
  import rbls_pkg::*;

  logic       s_valid_r;
  logic [1:0] s_req_r;
  logic [2:0] s_col_r;
  logic [2:0] s_row_r;
  logic       s_stone_r;
  logic [1:0] s_axis_r;

  board_t horiz_r, horiz_nxt;
  board_t vert_r,  vert_nxt;
  board_t diag_r,  diag_nxt;
  board_t anti_r,  anti_nxt;

  logic             o_valid_r;
  logic [OUT_W-1:0] o_mask_r;
  logic [OUT_W-1:0] o_mask_nxt;

  cell_geom_t geom;
  logic       s_adv;
  logic       in_fire;
  logic       present;
  row_t       line_full;

  rbls_cell_map u_map (
    .col  (s_col_r),
    .row  (s_row_r),
    .geom (geom)
  );

  assign s_adv    = s_valid_r && ((s_req_r != REQ_READ) || !o_valid_r || out_ready);
  assign in_ready = !s_valid_r || s_adv;
  assign in_fire  = in_valid && in_ready;
  assign present  = horiz_r[geom.y_idx][geom.x_idx];

  always_comb begin
    horiz_nxt = horiz_r;
    vert_nxt  = vert_r;
    diag_nxt  = diag_r;
    anti_nxt  = anti_r;
    case (s_req_r)
      REQ_PLACE: begin
        if (geom.on_board && (present != s_stone_r)) begin
          horiz_nxt[geom.y_idx][geom.x_idx]    = s_stone_r;
          vert_nxt[geom.x_idx][geom.y_idx]     = s_stone_r;
          diag_nxt[geom.diag_idx][geom.x_idx]  = s_stone_r;
          anti_nxt[geom.anti_idx][geom.x_idx]  = s_stone_r;
        end
      end
      REQ_CLEAR: begin
        horiz_nxt = '0;
        vert_nxt  = '0;
        diag_nxt  = '0;
        anti_nxt  = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case (s_axis_r)
      AXIS_HORIZ: line_full = horiz_r[geom.y_idx];
      AXIS_VERT:  line_full = vert_r[geom.x_idx];
      AXIS_DIAG:  line_full = diag_r[geom.diag_idx] & geom.diag_keep;
      default:    line_full = anti_r[geom.anti_idx] & geom.anti_keep;
    endcase
    o_mask_nxt = geom.on_board ? OUT_W'(line_full) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
      horiz_r   <= '0;
      vert_r    <= '0;
      diag_r    <= '0;
      anti_r    <= '0;
    end else begin
      if (in_fire) begin
        s_valid_r <= 1'b1;
      end else if (s_adv) begin
        s_valid_r <= 1'b0;
      end
      if (s_adv) begin
        horiz_r <= horiz_nxt;
        vert_r  <= vert_nxt;
        diag_r  <= diag_nxt;
        anti_r  <= anti_nxt;
      end
      if (s_adv && (s_req_r == REQ_READ)) begin
        o_valid_r <= 1'b1;
      end else if (out_ready) begin
        o_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s_req_r   <= in_req_type;
      s_col_r   <= in_col;
      s_row_r   <= in_row;
      s_stone_r <= in_stone;
      s_axis_r  <= in_axis;
    end
    if (s_adv && (s_req_r == REQ_READ)) begin
      o_mask_r <= o_mask_nxt;
    end
  end

  assign out_valid     = o_valid_r;
  assign out_line_mask = o_mask_r;

`ifndef SYNTH
  // Every stone appears exactly once in each of the four views.
  a_views_agree: assert property (@(posedge clk) disable iff (!rst_n)
    ($countones(horiz_r) == $countones(vert_r)) &&
    ($countones(horiz_r) == $countones(diag_r)) &&
    ($countones(horiz_r) == $countones(anti_r)))
    else $error("rotated views disagree on the stone count");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (s_adv && (s_req_r == REQ_CLEAR)) |=> (horiz_r == '0) && (anti_r == '0))
    else $error("board not empty after a clear item");

  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s_adv && (s_req_r == REQ_READ)) |=> out_valid)
    else $error("read item retired without a result");

  a_place_sets_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (s_adv && (s_req_r == REQ_PLACE) && geom.on_board) |=>
      (horiz_r[$past(geom.y_idx)][$past(geom.x_idx)] == $past(s_stone_r)))
    else $error("placed cell does not hold the requested value");
`endif

endmodule

// ===== hw/rtl/rbls_cell_map.sv =====
// Maps a cell (col,row) to its row indices in the four rotated views and to
// the keep masks of its wrapped diagonals. Depends on rbls_pkg.
`timescale 1ns / 1ps

module rbls_cell_map (
  input  logic [2:0]          col,
  input  logic [2:0]          row,
  output rbls_pkg::cell_geom_t geom
);
  import rbls_pkg::*;

  localparam logic [IDX_W:0] SIZE_W = (IDX_W+1)'(BOARD_SIZE);

  idx_t           x;
  idx_t           y;
  logic [IDX_W:0] diag_sum;
  logic [IDX_W:0] anti_sum;
  idx_t           d;
  idx_t           a;
  logic [IDX_W:0] t;

  assign x = IDX_W'(col);
  assign y = IDX_W'(row);

  // Both sums stay below twice the board size, so one subtract reduces them.
  assign diag_sum = {1'b0, x} + {1'b0, y};
  assign anti_sum = {1'b0, y} + SIZE_W - {1'b0, x};
  assign d = (diag_sum >= SIZE_W) ? IDX_W'(diag_sum - SIZE_W) : IDX_W'(diag_sum);
  assign a = (anti_sum >= SIZE_W) ? IDX_W'(anti_sum - SIZE_W) : IDX_W'(anti_sum);
  assign t = SIZE_W - {1'b0, a};

  always_comb begin
    geom.on_board = ({1'b0, x} < SIZE_W) && ({1'b0, y} < SIZE_W);
    geom.x_idx    = x;
    geom.y_idx    = y;
    geom.diag_idx = d;
    geom.anti_idx = a;
    for (int i = 0; i < BOARD_SIZE; i++) begin
      // A diagonal row holds two segments; the cell's side of the split wins.
      if (x <= d) begin
        geom.diag_keep[i] = (IDX_W'(i) <= d);
      end else begin
        geom.diag_keep[i] = (IDX_W'(i) > d);
      end
      if ({1'b0, x} >= t) begin
        geom.anti_keep[i] = ((IDX_W+1)'(i) >= t);
      end else begin
        geom.anti_keep[i] = ((IDX_W+1)'(i) < t);
      end
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for rotated_bitboard_line_store_core: place, read and clear requests
// are checked against a board model kept here. Depends on rbls_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;
  import rbls_pkg::*;

  // Request code the block must ignore.
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 10;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] in_req_type;
  logic [2:0] in_col;
  logic [2:0] in_row;
  logic       in_stone;
  logic [1:0] in_axis;
  logic       out_valid;
  logic       out_ready = 1'b1;
  logic [7:0] out_line_mask;

  rotated_bitboard_line_store_core DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_col        (in_col),
    .in_row        (in_row),
    .in_stone      (in_stone),
    .in_axis       (in_axis),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_line_mask (out_line_mask)
  );

  always #5 clk = ~clk;

  // Board model: the four rotated views.
  logic [BOARD_SIZE-1:0] horiz_view [BOARD_SIZE];
  logic [BOARD_SIZE-1:0] vert_view  [BOARD_SIZE];
  logic [BOARD_SIZE-1:0] diag_view  [BOARD_SIZE];
  logic [BOARD_SIZE-1:0] anti_view  [BOARD_SIZE];

  logic [7:0] line_mask_q [$];
  logic [7:0] want_mask;
  int         err_cnt = 0;
  int         cyc_cnt = 0;
  bit         idling_on = 1'b1;
  int         ready_stall = 0;

  task automatic report_err(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  function automatic logic [63:0] low_bits(input int n);
    if (n >= 64) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  task automatic wipe_board();
    for (int i = 0; i < BOARD_SIZE; i++) begin
      horiz_view[i] = '0;
      vert_view[i]  = '0;
      diag_view[i]  = '0;
      anti_view[i]  = '0;
    end
  endtask

  task automatic place_stone(input int x, input int y, input logic st);
    int d;
    int a;
    d = (x + y) % BOARD_SIZE;
    a = (y + BOARD_SIZE - x) % BOARD_SIZE;
    // The views only move when the stone actually changes.
    if (horiz_view[y][x] != st) begin
      horiz_view[y][x] = st;
      vert_view[x][y]  = st;
      diag_view[d][x]  = st;
      anti_view[a][x]  = st;
    end
  endtask

  function automatic logic [7:0] line_through(input logic [1:0] ax, input int x, input int y);
    int d;
    int a;
    int t;
    logic [63:0] row;
    logic [63:0] keep;
    row = '0;
    case (ax)
      AXIS_HORIZ: row = 64'(horiz_view[y]);
      AXIS_VERT:  row = 64'(vert_view[x]);
      AXIS_DIAG: begin
        // A wrapped diagonal row holds two diagonals; keep the cell's own.
        d = (x + y) % BOARD_SIZE;
        keep = low_bits(d + 1);
        row = (x <= d) ? (64'(diag_view[d]) & keep) : (64'(diag_view[d]) & ~keep);
      end
      default: begin
        a = (y + BOARD_SIZE - x) % BOARD_SIZE;
        t = BOARD_SIZE - a;
        keep = low_bits(t);
        row = (x >= t) ? (64'(anti_view[a]) & ~keep) : (64'(anti_view[a]) & keep);
      end
    endcase
    return row[7:0];
  endfunction

  task automatic apply_request(input logic [1:0] req, input logic [2:0] x, input logic [2:0] y,
                               input logic st, input logic [1:0] ax);
    bit on_board;
    on_board = (int'(x) < BOARD_SIZE) && (int'(y) < BOARD_SIZE);
    case (req)
      REQ_PLACE: if (on_board) place_stone(int'(x), int'(y), st);
      REQ_READ:  line_mask_q.push_back(on_board ? line_through(ax, int'(x), int'(y)) : 8'h00);
      REQ_CLEAR: wipe_board();
      default: ;
    endcase
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_req(input logic [1:0] req, input logic [2:0] x, input logic [2:0] y,
                          input logic st, input logic [1:0] ax);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_col      <= x;
    in_row      <= y;
    in_stone    <= st;
    in_axis     <= ax;
    do @(posedge clk); while (!in_ready);
    apply_request(req, x, y, st, ax);
    @(negedge clk);
  endtask

  task automatic read_all_axes(input logic [2:0] x, input logic [2:0] y);
    send_req(REQ_READ, x, y, 1'b0, AXIS_HORIZ);
    send_req(REQ_READ, x, y, 1'b1, AXIS_VERT);
    send_req(REQ_READ, x, y, 1'b0, AXIS_DIAG);
    send_req(REQ_READ, x, y, 1'b1, AXIS_ANTI);
  endtask

  // Returns 1 when the item is one the block acts on.
  task automatic send_random_item(output bit counted);
    int pick;
    logic [1:0] req;
    pick = $urandom_range(0, 99);
    if (pick < 50)      req = REQ_PLACE;
    else if (pick < 94) req = REQ_READ;
    else if (pick < 95) req = REQ_CLEAR;
    else                req = REQ_UNUSED;
    // Places mostly set stones so the board fills between clears.
    send_req(req, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
             (req == REQ_PLACE) ? ($urandom_range(0, 99) < 70) : 1'($urandom),
             2'($urandom_range(0, 3)));
    counted = (req != REQ_UNUSED);
  endtask

  task automatic send_random_run(input int count);
    int n;
    bit counted;
    n = 0;
    while (n < count) begin
      send_random_item(counted);
      if (counted) n++;
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (line_mask_q.size() != 0);
  endtask

  task automatic test_empty_board();
    read_all_axes(3'd0, 3'd0);
  endtask

  task automatic test_corners_and_wraps();
    send_req(REQ_PLACE, 3'd0, 3'd0, 1'b1, AXIS_ANTI);
    send_req(REQ_PLACE, 3'd7, 3'd7, 1'b1, AXIS_HORIZ);
    send_req(REQ_PLACE, 3'd7, 3'd0, 1'b1, AXIS_VERT);
    send_req(REQ_PLACE, 3'd0, 3'd7, 1'b1, AXIS_DIAG);
    send_req(REQ_PLACE, 3'd3, 3'd4, 1'b1, AXIS_HORIZ);
    read_all_axes(3'd3, 3'd4);
    // Cells at the board edge, read along diagonal rows that mostly wrap around it.
    send_req(REQ_READ, 3'd7, 3'd0, 1'b0, AXIS_DIAG);
    send_req(REQ_READ, 3'd7, 3'd7, 1'b0, AXIS_DIAG);
    send_req(REQ_READ, 3'd0, 3'd7, 1'b0, AXIS_ANTI);
    send_req(REQ_READ, 3'd7, 3'd0, 1'b0, AXIS_ANTI);
  endtask

  task automatic test_redundant_and_ignored();
    send_req(REQ_PLACE, 3'd3, 3'd4, 1'b1, AXIS_DIAG);
    send_req(REQ_PLACE, 3'd1, 3'd1, 1'b0, AXIS_DIAG);
    send_req(REQ_PLACE, 3'd0, 3'd0, 1'b0, AXIS_VERT);
    send_req(REQ_UNUSED, 3'd5, 3'd5, 1'b1, AXIS_ANTI);
    send_req(REQ_READ, 3'd5, 3'd0, 1'b1, AXIS_HORIZ);
  endtask

  task automatic test_clear();
    send_req(REQ_CLEAR, 3'd6, 3'd2, 1'b1, AXIS_VERT);
    send_req(REQ_READ, 3'd7, 3'd3, 1'b0, AXIS_VERT);
  endtask

  task automatic test_random_mix();
    send_random_run(850);
  endtask

  task automatic test_pause_until_drained();
    send_random_run(20);
    wait_drained();
    send_random_run(20);
  endtask

  task automatic test_back_to_back();
    idling_on = 1'b0;
    send_random_run(240);
  endtask

  // Result side: random stall bursts, only while idling is on.
  always @(negedge clk) begin
    if (ready_stall > 0) begin
      ready_stall <= ready_stall - 1;
      out_ready   <= 1'b0;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      ready_stall <= $urandom_range(0, 3);
      out_ready   <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (line_mask_q.size() == 0) begin
        report_err($sformatf("result with none expected, line_mask=%02h", out_line_mask));
      end else begin
        want_mask = line_mask_q.pop_front();
        if (out_line_mask !== want_mask)
          report_err($sformatf("line_mask %02h, expected %02h", out_line_mask, want_mask));
      end
    end
  end

  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_req_type = REQ_PLACE;
    in_col      = '0;
    in_row      = '0;
    in_stone    = 1'b0;
    in_axis     = AXIS_HORIZ;
    wipe_board();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_board();
    test_corners_and_wraps();
    test_redundant_and_ignored();
    test_clear();
    test_random_mix();
    test_pause_until_drained();
    test_back_to_back();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/rbls_pkg.sv
hw/rtl/rbls_cell_map.sv
hw/rtl/rotated_bitboard_line_store_core.sv
dv/tb_top.sv
